### rtl/stc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and register map for the servo track command parser
// no dependencies; used by stc_cfg_regs, stc_frame_parser, stc_axis_update and the top

package stc_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // frame letters
  localparam logic [7:0] ChX = 8'h78;
  localparam logic [7:0] ChA = 8'h61;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChY = 8'h79;
  localparam logic [7:0] ChC = 8'h63;
  localparam logic [7:0] ChD = 8'h64;

  // reset values
  localparam logic [11:0] PanStepRst  = 12'd20;
  localparam logic [15:0] PanMinRst   = 16'd1050;
  localparam logic [15:0] PanMaxRst   = 16'd4950;
  localparam logic [11:0] TiltStepRst = 12'd10;
  localparam logic [15:0] TiltMinRst  = 16'd3000;
  localparam logic [15:0] TiltMaxRst  = 16'd4000;
  localparam logic [15:0] PanPosRst   = 16'd3000;
  localparam logic [15:0] TiltPosRst  = 16'd3500;

  typedef enum logic [2:0] {
    REG_PAN_STEP  = 3'd0,
    REG_PAN_MIN   = 3'd1,
    REG_PAN_MAX   = 3'd2,
    REG_TILT_STEP = 3'd3,
    REG_TILT_MIN  = 3'd4,
    REG_TILT_MAX  = 3'd5
  } reg_idx_e;

  // parser phase codes
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_SEC_HI = 3'd2,
    PH_SEC_LO = 3'd3,
    PH_FST_HI = 3'd4,
    PH_FST_LO = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    FRAME_NONE   = 2'd0,
    FRAME_FIRST  = 2'd1,
    FRAME_SECOND = 2'd2
  } frame_e;

  typedef struct packed {
    logic [7:0] start;
    logic [7:0] first;
    logic [7:0] second;
  } letters_t;

  localparam letters_t XLetters = '{start: ChX, first: ChA, second: ChB};
  localparam letters_t YLetters = '{start: ChY, first: ChC, second: ChD};

  typedef struct packed {
    frame_e      kind;
    logic [15:0] value;
  } parse_res_t;

  typedef struct packed {
    logic [11:0] pan_step;
    logic [15:0] pan_min;
    logic [15:0] pan_max;
    logic [11:0] tilt_step;
    logic [15:0] tilt_min;
    logic [15:0] tilt_max;
  } cfg_t;

  typedef struct packed {
    logic [15:0] pan_compare;
    logic [15:0] tilt_compare;
    logic [1:0]  x_frame;
    logic [1:0]  y_frame;
    logic [15:0] x_value;
    logic [15:0] y_value;
  } result_t;

endpackage

### rtl/stc_byte_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one received byte
// standalone, no package needed

interface stc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/stc_result_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one result per received byte
// standalone, no package needed

interface stc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] pan_compare;
  logic [15:0] tilt_compare;
  logic [1:0]  x_frame;
  logic [1:0]  y_frame;
  logic [15:0] x_value;
  logic [15:0] y_value;

  modport source (output valid, output pan_compare, output tilt_compare, output x_frame,
                  output y_frame, output x_value, output y_value, input ready);
  modport sink   (input valid, input pan_compare, input tilt_compare, input x_frame,
                  input y_frame, input x_value, input y_value, output ready);
endinterface

### rtl/stc_cfg_regs.sv
`timescale 1ns / 1ps
// apb configuration registers: steps and clamp bounds for both axes
// depends on stc_pkg

module stc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [stc_pkg::AddrW-1:0]  paddr,
  input  logic [stc_pkg::DataW-1:0]  pwdata,
  output logic [stc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output stc_pkg::cfg_t              cfg_o
);

  stc_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pan_step  <= stc_pkg::PanStepRst;
      cfg_q.pan_min   <= stc_pkg::PanMinRst;
      cfg_q.pan_max   <= stc_pkg::PanMaxRst;
      cfg_q.tilt_step <= stc_pkg::TiltStepRst;
      cfg_q.tilt_min  <= stc_pkg::TiltMinRst;
      cfg_q.tilt_max  <= stc_pkg::TiltMaxRst;
    end else if (wr_en) begin
      unique case (idx)
        stc_pkg::REG_PAN_STEP:  cfg_q.pan_step  <= pwdata[11:0];
        stc_pkg::REG_PAN_MIN:   cfg_q.pan_min   <= pwdata[15:0];
        stc_pkg::REG_PAN_MAX:   cfg_q.pan_max   <= pwdata[15:0];
        stc_pkg::REG_TILT_STEP: cfg_q.tilt_step <= pwdata[11:0];
        stc_pkg::REG_TILT_MIN:  cfg_q.tilt_min  <= pwdata[15:0];
        stc_pkg::REG_TILT_MAX:  cfg_q.tilt_max  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      stc_pkg::REG_PAN_STEP:  prdata = {20'd0, cfg_q.pan_step};
      stc_pkg::REG_PAN_MIN:   prdata = {16'd0, cfg_q.pan_min};
      stc_pkg::REG_PAN_MAX:   prdata = {16'd0, cfg_q.pan_max};
      stc_pkg::REG_TILT_STEP: prdata = {20'd0, cfg_q.tilt_step};
      stc_pkg::REG_TILT_MIN:  prdata = {16'd0, cfg_q.tilt_min};
      stc_pkg::REG_TILT_MAX:  prdata = {16'd0, cfg_q.tilt_max};
      default:                prdata = '0;
    endcase
  end

endmodule

### rtl/stc_frame_parser.sv
`timescale 1ns / 1ps
// one frame parser: start letter, kind letter, high and low payload byte
// holds its phase, payload latches and the two per-kind byte counts; uses stc_pkg

module stc_frame_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stc_pkg::letters_t    letters_i,
  input  logic                 fire_i,
  input  logic [7:0]           byte_i,
  output stc_pkg::parse_res_t  res_o
);

  stc_pkg::phase_e phase_q, phase_d;
  logic [7:0]      hi_q, hi_d, lo_q, lo_d;
  logic [1:0]      cnt_fst_q, cnt_fst_d, cnt_sec_q, cnt_sec_d;
  stc_pkg::frame_e kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= stc_pkg::PH_IDLE;
      hi_q      <= '0;
      lo_q      <= '0;
      cnt_fst_q <= '0;
      cnt_sec_q <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      hi_q      <= hi_d;
      lo_q      <= lo_d;
      cnt_fst_q <= cnt_fst_d;
      cnt_sec_q <= cnt_sec_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    cnt_fst_d = cnt_fst_q;
    cnt_sec_d = cnt_sec_q;
    kind      = stc_pkg::FRAME_NONE;

    // start letter restarts even mid-payload; counts survive the restart
    if (byte_i == letters_i.start) begin
      phase_d = stc_pkg::PH_START;
    end else if (byte_i == letters_i.first && phase_q == stc_pkg::PH_START) begin
      phase_d = stc_pkg::PH_FST_HI;
    end else if (byte_i == letters_i.second && phase_q == stc_pkg::PH_START) begin
      phase_d = stc_pkg::PH_SEC_HI;
    end else begin
      unique case (phase_q)
        stc_pkg::PH_FST_HI: begin
          hi_d      = byte_i;
          phase_d   = stc_pkg::PH_FST_LO;
          cnt_fst_d = cnt_fst_q + 2'd1;
        end
        stc_pkg::PH_SEC_HI: begin
          hi_d      = byte_i;
          phase_d   = stc_pkg::PH_SEC_LO;
          cnt_sec_d = cnt_sec_q + 2'd1;
        end
        stc_pkg::PH_FST_LO: begin
          lo_d      = byte_i;
          cnt_fst_d = cnt_fst_q + 2'd1;
        end
        stc_pkg::PH_SEC_LO: begin
          lo_d      = byte_i;
          cnt_sec_d = cnt_sec_q + 2'd1;
        end
        default: ;
      endcase
    end

    if (cnt_fst_d == 2'd2) begin
      cnt_fst_d = '0;
      phase_d   = stc_pkg::PH_IDLE;
      kind      = stc_pkg::FRAME_FIRST;
    end
    if (cnt_sec_d == 2'd2) begin
      cnt_sec_d = '0;
      phase_d   = stc_pkg::PH_IDLE;
      kind      = stc_pkg::FRAME_SECOND;
    end

    res_o.kind  = kind;
    res_o.value = (kind == stc_pkg::FRAME_NONE) ? 16'd0 : {hi_d, lo_d};
  end

endmodule

### rtl/stc_clamp_step.sv
`timescale 1ns / 1ps
// steps a compare value up or down by a step and clamps in the step direction
// purely combinational; no package needed

module stc_clamp_step (
  input  logic [15:0] pos_i,
  input  logic [11:0] step_i,
  input  logic [15:0] lo_i,
  input  logic [15:0] hi_i,
  input  logic        up_i,
  output logic [15:0] pos_o
);

  logic [16:0] sum;
  logic [16:0] diff;

  assign sum  = {1'b0, pos_i} + {5'd0, step_i};
  assign diff = {1'b0, pos_i} - {5'd0, step_i};

  always_comb begin
    if (up_i) begin
      pos_o = (sum > {1'b0, hi_i}) ? hi_i : sum[15:0];
    end else begin
      // diff[16] set means the step went below zero
      pos_o = (diff[16] || diff[15:0] < lo_i) ? lo_i : diff[15:0];
    end
  end

endmodule

### rtl/stc_axis_update.sv
`timescale 1ns / 1ps
// next compare value for one servo axis from a parsed frame
// wraps stc_clamp_step; depends on stc_pkg

module stc_axis_update (
  input  logic                 fire_i,
  input  stc_pkg::parse_res_t  frame_i,
  input  logic                 up_on_first_i,
  input  logic [15:0]          pos_i,
  input  logic [11:0]          step_i,
  input  logic [15:0]          lo_i,
  input  logic [15:0]          hi_i,
  output logic                 move_o,
  output logic [15:0]          pos_o
);

  logic        up;
  logic [15:0] stepped;

  // first kind moves up on one axis and down on the other
  assign up     = (frame_i.kind == stc_pkg::FRAME_FIRST) ? up_on_first_i : !up_on_first_i;
  assign move_o = fire_i && (frame_i.kind != stc_pkg::FRAME_NONE) && (frame_i.value != 16'd0);

  stc_clamp_step u_clamp (
    .pos_i  (pos_i),
    .step_i (step_i),
    .lo_i   (lo_i),
    .hi_i   (hi_i),
    .up_i   (up),
    .pos_o  (stepped)
  );

  assign pos_o = move_o ? stepped : pos_i;

endmodule

### rtl/servo_track_command_parser.sv
`timescale 1ns / 1ps
// servo track command parser top: input byte register, two frame parsers,
// axis updates and result register; depends on stc_pkg, stc_byte_if, stc_result_if
//
//   channel   dir   handshake            payload
//   rx_i      in    valid/ready          rx_byte
//   res_o     out   valid/ready          pan/tilt compare, x/y frame, x/y value
//   cfg       in    apb (psel..pready)   six 32-bit registers at 4*index
//
// one byte per cycle sustained while results are taken; a byte passes through the input register
// and then through the result register, which drives res_o.
// state and results update when the input register moves into the result register.
// while a result stalls the input register can still take one byte, then holds it
// and drops ready. reset is asynchronous and restores the register and position defaults.

module servo_track_command_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  stc_byte_if.sink                   rx_i,
  stc_result_if.source               res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [stc_pkg::AddrW-1:0]  paddr,
  input  logic [stc_pkg::DataW-1:0]  pwdata,
  output logic [stc_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  stc_pkg::cfg_t       cfg;
  stc_pkg::parse_res_t x_res, y_res;
  stc_pkg::result_t    out_q;

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        out_valid_q;
  logic        fire;
  logic [15:0] pan_q, pan_d, tilt_q, tilt_d;
  logic        pan_move, tilt_move;

  stc_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // byte moves into the result register when that register is free or draining
  assign fire     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      s1_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_byte_q <= rx_i.rx_byte;
    end
  end

  stc_frame_parser u_x_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .letters_i (stc_pkg::XLetters),
    .fire_i    (fire),
    .byte_i    (s1_byte_q),
    .res_o     (x_res)
  );

  stc_frame_parser u_y_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .letters_i (stc_pkg::YLetters),
    .fire_i    (fire),
    .byte_i    (s1_byte_q),
    .res_o     (y_res)
  );

  stc_axis_update u_pan (
    .fire_i        (fire),
    .frame_i       (x_res),
    .up_on_first_i (1'b1),
    .pos_i         (pan_q),
    .step_i        (cfg.pan_step),
    .lo_i          (cfg.pan_min),
    .hi_i          (cfg.pan_max),
    .move_o        (pan_move),
    .pos_o         (pan_d)
  );

  stc_axis_update u_tilt (
    .fire_i        (fire),
    .frame_i       (y_res),
    .up_on_first_i (1'b0),
    .pos_i         (tilt_q),
    .step_i        (cfg.tilt_step),
    .lo_i          (cfg.tilt_min),
    .hi_i          (cfg.tilt_max),
    .move_o        (tilt_move),
    .pos_o         (tilt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q  <= stc_pkg::PanPosRst;
      tilt_q <= stc_pkg::TiltPosRst;
    end else begin
      if (pan_move) begin
        pan_q <= pan_d;
      end
      if (tilt_move) begin
        tilt_q <= tilt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.pan_compare  <= pan_d;
      out_q.tilt_compare <= tilt_d;
      out_q.x_frame      <= x_res.kind;
      out_q.y_frame      <= y_res.kind;
      out_q.x_value      <= x_res.value;
      out_q.y_value      <= y_res.value;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.pan_compare  = out_q.pan_compare;
  assign res_o.tilt_compare = out_q.tilt_compare;
  assign res_o.x_frame      = out_q.x_frame;
  assign res_o.y_frame      = out_q.y_frame;
  assign res_o.x_value      = out_q.x_value;
  assign res_o.y_value      = out_q.y_value;

  // a byte held in the input register is never dropped or changed
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !fire |=> s1_valid_q && $stable(s1_byte_q))
    else $error("input byte lost while result stalled");

  // compare values only move when a byte is processed
  a_pos_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(pan_q) && $stable(tilt_q))
    else $error("servo position moved without a byte");

  // an x frame with nothing completed reports a zero value
  a_no_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && x_res.kind == stc_pkg::FRAME_NONE |-> x_res.value == 16'd0)
    else $error("x value nonzero without a frame");

  // the result register shows the position the axis just took
  a_result_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q && out_q.pan_compare == pan_q && out_q.tilt_compare == tilt_q)
    else $error("result disagrees with servo position");

endmodule
